@@ rtl/gmpu_pkg.sv @@
// Shared types and constants for the graphics mode pixel unpacker.
`default_nettype none
package gmpu_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLORS_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HORZ_SHIFT = 3'd4;

    localparam logic [2:0] MODE_HIRES   = 3'd0;
    localparam logic [2:0] MODE_LUMA    = 3'd1;
    localparam logic [2:0] MODE_PALETTE = 3'd2;
    localparam logic [2:0] MODE_HUE     = 3'd3;
    localparam logic [2:0] MODE_FOUR    = 3'd4;

    localparam logic [1:0] SHIFT_RIGHT = 2'b01;
    localparam logic [1:0] SHIFT_LEFT  = 2'b11;

    localparam logic [6:0] LINE_BYTES_RESET = 7'd40;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] colors_low;
        logic [7:0]  background;
        logic [6:0]  line_bytes;
        logic [1:0]  horz_shift;
    } cfg_t;

    typedef struct packed {
        logic [7:0] cur_byte;
        logic [7:0] prev_byte;
        logic       first;
        logic       last;
    } desc_t;

endpackage
`default_nettype wire

@@ rtl/graphics_mode_pixel_unpacker_top.sv @@
// Top level: configuration registers, front end, descriptor queue and pixel back end.
// An accepted item passes a queue entry and the descriptor register to the output register,
// which gives one pixel per cycle unless out_stall is high or the queue runs dry: 7 to 9
// pixels per video byte (8 with no shift); the two-entry queue takes bytes ahead of the back end.
// Reset (rst_n, asynchronous, active low) empties the queue and output, restarts the line
// and loads the register reset values.
`default_nettype none
module graphics_mode_pixel_unpacker_top #(
    parameter int MAX_LINE_BYTES = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        video_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [7:0]                             pixel_color,
    output logic                                   run_last,
    output logic                                   line_end,
    input  wire logic                              wr_en,
    input  wire logic [gmpu_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [gmpu_pkg::CFG_DATA_W-1:0]   wr_data
);
    import gmpu_pkg::*;

    cfg_t  cfg_reg;
    desc_t front_desc;
    desc_t q_head;
    logic  q_full;
    logic  q_not_empty;
    logic  q_pop;
    logic  accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_HIRES;
            cfg_reg.colors_low <= '0;
            cfg_reg.background <= '0;
            cfg_reg.line_bytes <= LINE_BYTES_RESET;
            cfg_reg.horz_shift <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MODE:       cfg_reg.mode       <= wr_data[2:0];
                REG_COLORS_LOW: cfg_reg.colors_low <= wr_data;
                REG_BACKGROUND: cfg_reg.background <= wr_data[7:0];
                REG_LINE_BYTES: cfg_reg.line_bytes <= wr_data[6:0];
                REG_HORZ_SHIFT: cfg_reg.horz_shift <= wr_data[1:0];
                default:        ;
            endcase
        end
    end

    gmpu_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .video_byte (video_byte),
        .line_bytes (cfg_reg.line_bytes),
        .desc       (front_desc)
    );

    gmpu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_desc (front_desc),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    gmpu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_head      (q_head),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pixel_color (pixel_color),
        .run_last    (run_last),
        .line_end    (line_end)
    );

endmodule
`default_nettype wire

@@ rtl/gmpu_front.sv @@
// Front end: takes video bytes, tracks line position and carried byte, builds descriptors.
`default_nettype none
module gmpu_front #(
    parameter int MAX_LINE_BYTES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     video_byte,
    input  wire logic [6:0]     line_bytes,
    output gmpu_pkg::desc_t     desc
);
    import gmpu_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_LINE_BYTES);

    logic [6:0] pos_reg;
    logic [7:0] carried_reg;
    logic [7:0] len;
    logic       last;

    always_comb
    begin
        if (line_bytes == 7'd0)
            len = 8'd1;
        else if ({1'b0, line_bytes} > MaxLen)
            len = MaxLen;
        else
            len = {1'b0, line_bytes};
        last = (({1'b0, pos_reg} + 8'd1) >= len);
        desc.cur_byte  = video_byte;
        desc.prev_byte = carried_reg;
        desc.first     = (pos_reg == 7'd0);
        desc.last      = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            carried_reg <= '0;
        end
        else if (accept)
        begin
            carried_reg <= video_byte;
            pos_reg     <= last ? 7'd0 : (pos_reg + 7'd1);
        end
    end

endmodule
`default_nettype wire

@@ rtl/gmpu_queue.sv @@
// Two-entry descriptor queue between front and back.
`default_nettype none
module gmpu_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire gmpu_pkg::desc_t push_desc,
    input  wire logic           pop,
    output gmpu_pkg::desc_t     head,
    output logic                full,
    output logic                not_empty
);
    import gmpu_pkg::*;

    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head      = entry_reg[rd_ptr_reg];
    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/gmpu_back.sv @@
// Back end: walks the pixel slots of each descriptor and drives the output register.
`default_nettype none
module gmpu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gmpu_pkg::cfg_t cfg,
    input  wire gmpu_pkg::desc_t q_head,
    input  wire logic           q_not_empty,
    output logic                q_pop,
    input  wire logic           out_stall,
    output logic                out_valid,
    output logic [7:0]          pixel_color,
    output logic                run_last,
    output logic                line_end
);
    import gmpu_pkg::*;

    desc_t      desc_reg;
    logic       active_reg;
    logic [3:0] slot_reg;
    logic       out_valid_reg;
    logic [7:0] color_reg;
    logic       run_last_reg;
    logic       line_end_reg;

    logic       out_free;
    logic [3:0] end_slot;
    logic [3:0] start_slot;
    logic       at_end;
    logic [7:0] src_byte;
    logic [2:0] src_idx;
    logic       zero_px;
    logic [7:0] px;

    function automatic logic [7:0] reg_of(input cfg_t c, input logic [3:0] n);
        logic [7:0] r;
        if (n[3])
            r = c.background;
        else
            r = c.colors_low[{n[2:0], 3'b000} +: 8];
        return r;
    endfunction

    function automatic logic [7:0] decode(input cfg_t c, input logic [7:0] b,
                                          input logic [2:0] i);
        logic [3:0] nib;
        logic [1:0] k;
        logic [7:0] r;
        nib = i[2] ? b[3:0] : b[7:4];
        k   = {b[3'd7 - {i[2:1], 1'b0}], b[3'd6 - {i[2:1], 1'b0}]};
        case (c.mode)
            MODE_HIRES:   r = (b[3'd7 - i] ? reg_of(c, 4'd5) : reg_of(c, 4'd6)) & 8'hFE;
            MODE_LUMA:    r = {c.background[7:4], nib};
            MODE_PALETTE: r = reg_of(c, nib);
            MODE_HUE:     r = {nib, c.background[3:0]};
            MODE_FOUR:
            begin
                case (k)
                    2'd0:    r = reg_of(c, 4'd8) & 8'hFE;
                    2'd1:    r = reg_of(c, 4'd4) & 8'hFE;
                    2'd2:    r = reg_of(c, 4'd5) & 8'hFE;
                    default: r = reg_of(c, 4'd6) & 8'hFE;
                endcase
            end
            default:      r = 8'h00;
        endcase
        return r;
    endfunction

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        end_slot   = (cfg.horz_shift == SHIFT_LEFT && desc_reg.last) ? 4'd8 : 4'd7;
        start_slot = (cfg.horz_shift == SHIFT_LEFT && q_head.first) ? 4'd1 : 4'd0;
        at_end     = (slot_reg == end_slot);
        q_pop      = q_not_empty && (!active_reg || (out_free && at_end));

        src_byte = desc_reg.cur_byte;
        src_idx  = slot_reg[2:0];
        zero_px  = 1'b0;
        if (cfg.horz_shift == SHIFT_RIGHT)
        begin
            if (slot_reg == 4'd0)
            begin
                src_byte = desc_reg.prev_byte;
                src_idx  = 3'd7;
                zero_px  = desc_reg.first;
            end
            else
                src_idx = 3'(slot_reg - 4'd1);
        end
        else if (cfg.horz_shift == SHIFT_LEFT)
            zero_px = slot_reg[3];
        px = zero_px ? 8'h00 : decode(cfg, src_byte, src_idx);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            desc_reg <= q_head;
        if (out_free && active_reg)
        begin
            color_reg    <= px;
            run_last_reg <= at_end;
            line_end_reg <= at_end && desc_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= active_reg;
            if (q_pop)
            begin
                active_reg <= 1'b1;
                slot_reg   <= start_slot;
            end
            else if (out_free && active_reg)
            begin
                if (at_end)
                    active_reg <= 1'b0;
                else
                    slot_reg <= slot_reg + 4'd1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = color_reg;
    assign run_last    = run_last_reg;
    assign line_end    = line_end_reg;

endmodule
`default_nettype wire

@@ rtl/gmpu_checker.sv @@
// Port-level checks for the pixel unpacker, bound to the top level.
`default_nettype none
module gmpu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] pixel_color,
    input wire logic       run_last,
    input wire logic       line_end
);
    logic [3:0] pending_reg;
    logic       in_acc;
    logic       last_acc;

    assign in_acc   = in_valid && !in_stall;
    assign last_acc = out_valid && !out_stall && run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_acc && !last_acc)
            pending_reg <= pending_reg + 4'd1;
        else if (last_acc && !in_acc)
            pending_reg <= pending_reg - 4'd1;
    end

    a_line_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> run_last)
        else $error("line end without run end");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_color))
        else $error("stalled pixel changed");

    a_no_spurious_run: assert property (@(posedge clk) disable iff (!rst_n)
        last_acc |-> pending_reg != 4'd0)
        else $error("run ended with no item outstanding");

    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("too many items outstanding");

endmodule

bind graphics_mode_pixel_unpacker_top gmpu_checker u_gmpu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_color (pixel_color),
    .run_last    (run_last),
    .line_end    (line_end)
);
`default_nettype wire
